// File: src/ptm_pkg.sv
`timescale 1ns / 1ps
package ptm_pkg;
	localparam int VALUE_BITS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;
	localparam logic [15:0] LOW_THR_RST  = 16'd6554;
	localparam logic [15:0] MID_THR_RST  = 16'd16384;
	localparam logic [15:0] HIGH_THR_RST = 16'd29491;
	localparam logic [1:0] REG_LOW  = 2'd0;
	localparam logic [1:0] REG_MID  = 2'd1;
	localparam logic [1:0] REG_HIGH = 2'd2;
	localparam int DIV_NUM_BITS = 48;
	localparam int DIV_DEN_BITS = 49;

	typedef struct packed {
		logic track;      // accumulate accepted sample
		logic calc_start; // latch result operands, start divisions
		logic out_load;   // copy result into output register
	} ptm_cmd_t;

	typedef struct packed {
		logic div_done;
	} ptm_sts_t;
endpackage

// File: src/ptm_div.sv
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, saturated to 32 bits.
module ptm_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [ptm_pkg::DIV_NUM_BITS-1:0] num,
	input  logic signed [ptm_pkg::DIV_DEN_BITS-1:0] den,
	output logic                                  busy,
	output logic [31:0]                           quot
);
	import ptm_pkg::*;
	localparam int CW = $clog2(DIV_NUM_BITS + 1);

	logic [DIV_NUM_BITS-1:0] q_q;
	logic [DIV_DEN_BITS:0]   rem_q;
	logic [DIV_DEN_BITS-1:0] den_q;
	logic                    neg_q;
	logic [CW-1:0]           cnt_q;
	logic [DIV_DEN_BITS:0]   rem_sh;
	logic [DIV_DEN_BITS:0]   rem_sub;
	logic [DIV_NUM_BITS:0]   sq;

	assign rem_sh  = {rem_q[DIV_DEN_BITS-1:0], q_q[DIV_NUM_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CW'(DIV_NUM_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[DIV_NUM_BITS-1] ? DIV_NUM_BITS'(-num) : num;
			den_q <= den[DIV_DEN_BITS-1] ? DIV_DEN_BITS'(-den) : den;
			rem_q <= '0;
			neg_q <= num[DIV_NUM_BITS-1] ^ den[DIV_DEN_BITS-1];
		end else if (busy) begin
			if (!rem_sub[DIV_DEN_BITS]) begin
				rem_q <= rem_sub;
				q_q   <= {q_q[DIV_NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[DIV_NUM_BITS-2:0], 1'b0};
			end
		end
	end

	// saturate magnitude with sign
	always_comb begin
		sq = neg_q ? -{1'b0, q_q} : {1'b0, q_q};
		if (!neg_q && q_q > DIV_NUM_BITS'(32'h7FFF_FFFF))
			quot = 32'h7FFF_FFFF;
		else if (neg_q && q_q > DIV_NUM_BITS'(33'h8000_0000))
			quot = 32'h8000_0000;
		else
			quot = sq[31:0];
	end
endmodule

// File: src/ptm_datapath.sv
`timescale 1ns / 1ps
module ptm_datapath #(
	parameter int VALUE_BITS = ptm_pkg::VALUE_BITS_DEF,
	parameter int TIME_BITS  = ptm_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptm_pkg::ptm_cmd_t     cmd,
	output ptm_pkg::ptm_sts_t     sts,
	input  logic [15:0]           low_thr,
	input  logic [15:0]           mid_thr,
	input  logic [15:0]           high_thr,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic [TIME_BITS-1:0]  sample_time,
	input  logic                  window_start,
	input  logic                  peak_marker,
	output logic signed [32:0]    time_to_peak,
	output logic signed [32:0]    rise_time,
	output logic signed [32:0]    decay_time,
	output logic signed [32:0]    half_max_width,
	output logic [31:0]           transient_time,
	output logic signed [31:0]    rise_slope,
	output logic signed [31:0]    decay_slope,
	output logic [4:0]            valid_mask
);
	import ptm_pkg::*;
	localparam int VB = VALUE_BITS;
	localparam int TB = TIME_BITS;

	logic [TB-1:0] start_time_q, peak_time_q, first_low_time_q, first_mid_time_q;
	logic [TB-1:0] last_mid_time_q, last_low_time_q, last_high_time_q, end_time_q;
	logic [VB-1:0] peak_value_q, first_low_value_q, last_low_value_q, last_high_value_q;
	logic [2:0]    found_q;
	logic [2:0]    found_base;
	logic          gt_low, gt_mid, gt_high;
	logic [TB-1:0] pk_t;
	logic [VB-1:0] pk_v;

	assign gt_low  = 32'(sample_value) > 32'(low_thr);
	assign gt_mid  = 32'(sample_value) > 32'(mid_thr);
	assign gt_high = 32'(sample_value) > 32'(high_thr);
	assign found_base = window_start ? 3'b000 : found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0; peak_time_q <= '0; peak_value_q <= '0;
			first_low_time_q <= '0; first_low_value_q <= '0;
			first_mid_time_q <= '0; last_mid_time_q <= '0;
			last_low_time_q <= '0; last_low_value_q <= '0;
			last_high_time_q <= '0; last_high_value_q <= '0;
			found_q <= '0; end_time_q <= '0;
		end else if (cmd.track) begin
			end_time_q <= sample_time;
			if (window_start) start_time_q <= sample_time;
			if (window_start || peak_marker) begin
				peak_time_q  <= sample_time;
				peak_value_q <= sample_value;
			end
			if (gt_low) begin
				if (!found_base[0]) begin
					first_low_time_q  <= sample_time;
					first_low_value_q <= sample_value;
				end
				last_low_time_q  <= sample_time;
				last_low_value_q <= sample_value;
			end
			if (gt_mid) begin
				if (!found_base[1]) first_mid_time_q <= sample_time;
				last_mid_time_q <= sample_time;
			end
			if (gt_high) begin
				last_high_time_q  <= sample_time;
				last_high_value_q <= sample_value;
			end
			found_q <= found_base | {gt_high, gt_mid, gt_low};
		end
	end
	assign pk_t = peak_time_q;
	assign pk_v = peak_value_q;

	// slope operands
	logic signed [DIV_NUM_BITS-1:0] rnum, dnum;
	logic signed [DIV_DEN_BITS-1:0] rden, dden;
	logic rz, dz;
	assign rnum = DIV_NUM_BITS'(($signed({1'b0, pk_v}) - $signed({1'b0, first_low_value_q}))) <<< 16;
	assign dnum = DIV_NUM_BITS'(($signed({1'b0, last_low_value_q})
		- $signed({1'b0, last_high_value_q}))) <<< 16;
	assign rden = DIV_DEN_BITS'($signed({1'b0, pk_t}) - $signed({1'b0, first_low_time_q}));
	assign dden = DIV_DEN_BITS'($signed({1'b0, last_low_time_q})
		- $signed({1'b0, last_high_time_q}));
	assign rz = (pk_t == first_low_time_q);
	assign dz = (last_low_time_q == last_high_time_q);

	logic rbusy, dbusy;
	logic [31:0] rq, dq;
	logic [4:0]  mask_q;
	logic        started_q;

	ptm_div u_rdiv (.clk, .arst_n, .start(cmd.calc_start), .num(rnum), .den(rden),
		.busy(rbusy), .quot(rq));
	ptm_div u_ddiv (.clk, .arst_n, .start(cmd.calc_start), .num(dnum), .den(dden),
		.busy(dbusy), .quot(dq));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			started_q <= 1'b0;
		end else begin
			if (cmd.calc_start) begin
				mask_q <= {found_q[1], found_q[0] & found_q[2] & !dz, found_q[0],
					found_q[0] & !rz, found_q[0]};
				started_q <= 1'b1;
			end else if (cmd.out_load) started_q <= 1'b0;
		end
	end
	assign sts.div_done = started_q && !rbusy && !dbusy;

	function automatic logic [32:0] d33(input logic [TB-1:0] a, input logic [TB-1:0] b);
		logic [TB:0] d;
		d = {1'b0, a} - {1'b0, b};
		return 33'($signed(d));
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			time_to_peak   <= d33(pk_t, start_time_q);
			rise_time      <= mask_q[0] ? d33(pk_t, first_low_time_q) : '0;
			decay_time     <= mask_q[2] ? d33(last_low_time_q, pk_t) : '0;
			half_max_width <= mask_q[4] ? d33(last_mid_time_q, first_mid_time_q) : '0;
			transient_time <= 32'(end_time_q - start_time_q);
			rise_slope     <= mask_q[1] ? rq : '0;
			decay_slope    <= mask_q[3] ? dq : '0;
			valid_mask     <= mask_q;
		end
	end
endmodule

// File: src/ptm_ctrl.sv
`timescale 1ns / 1ps
module ptm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              window_end,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ptm_pkg::ptm_sts_t sts,
	output ptm_pkg::ptm_cmd_t cmd
);
	import ptm_pkg::*;
	typedef enum logic [1:0] {IDLE, START, DIVIDE} state_t;
	state_t state_q;
	logic   acc;

	// during division no sample is taken; result held until out side frees
	assign in_stall = (state_q != IDLE) || (out_valid && out_stall && window_end);
	assign acc = in_valid && !in_stall;
	assign cmd.track = acc;
	assign cmd.calc_start = (state_q == START);
	assign cmd.out_load = (state_q == DIVIDE) && sts.div_done && !(out_valid && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				IDLE:   if (acc && window_end) state_q <= START;
				START:  state_q <= DIVIDE;
				DIVIDE: if (cmd.out_load) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

// File: src/pulse_transient_metrics.sv
`timescale 1ns / 1ps
// Pulse rise/decay/width measurement. Plain samples are taken one per cycle.
// The sample marked window_end starts two 48-step shift-subtract dividers
// for the slopes; no samples are taken then, so the result is registered and
// the next sample is accepted only once both dividers have finished.
// A result waiting on out_stall only holds off the next window end.
module pulse_transient_metrics #(
	parameter int VALUE_BITS = ptm_pkg::VALUE_BITS_DEF,
	parameter int TIME_BITS  = ptm_pkg::TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] sample_value,
	input  logic [TIME_BITS-1:0]  sample_time,
	input  logic                  window_start,
	input  logic                  window_end,
	input  logic                  peak_marker,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [32:0]    time_to_peak,
	output logic signed [32:0]    rise_time,
	output logic signed [32:0]    decay_time,
	output logic signed [32:0]    half_max_width,
	output logic [31:0]           transient_time,
	output logic signed [31:0]    rise_slope,
	output logic signed [31:0]    decay_slope,
	output logic [4:0]            valid_mask
);
	import ptm_pkg::*;
	logic [15:0] low_q, mid_q, high_q;
	ptm_cmd_t cmd;
	ptm_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= LOW_THR_RST; mid_q <= MID_THR_RST; high_q <= HIGH_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_MID:  mid_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ptm_ctrl u_ctrl (.clk, .arst_n, .in_valid, .window_end, .in_stall, .out_valid,
		.out_stall, .sts, .cmd);

	ptm_datapath #(.VALUE_BITS(VALUE_BITS), .TIME_BITS(TIME_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .low_thr(low_q), .mid_thr(mid_q), .high_thr(high_q),
		.sample_value, .sample_time, .window_start, .peak_marker, .time_to_peak,
		.rise_time, .decay_time, .half_max_width, .transient_time, .rise_slope,
		.decay_slope, .valid_mask);

	a_mask_rise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!valid_mask[1] || valid_mask[0])) else $error("slope without crossing");
	a_mask_decay: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!valid_mask[3] || valid_mask[2])) else $error("decay slope mask");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.track && cmd.calc_start)) else $error("track during divide");
endmodule

// File: tb/pulse_transient_metrics_test.sv
`timescale 1ns / 1ps
module pulse_transient_metrics_test;
	import ptm_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind this index
	localparam int SETTLE = 60;               // margin for a window end to finish its divisions
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [15:0] value;
		logic [31:0] stamp;
		bit ws, we, pk;
	} sample_t;

	typedef struct {
		logic [32:0] ttp, rise, decay, hmw;
		logic [31:0] trans, rslope, dslope;
		logic [4:0] mask;
	} metrics_t;

	typedef struct {
		sample_t s;
		bit typed;
		metrics_t want;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0, in_stall;
	logic [15:0] sample_value = '0;
	logic [31:0] sample_time = '0;
	logic window_start = 0, window_end = 0, peak_marker = 0;
	logic out_valid, out_stall = 0;
	logic signed [32:0] time_to_peak, rise_time, decay_time, half_max_width;
	logic [31:0] transient_time;
	logic signed [31:0] rise_slope, decay_slope;
	logic [4:0] valid_mask;

	pulse_transient_metrics DUT (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor copy of thresholds and tracking state
	logic [15:0] thr_low, thr_mid, thr_high;
	logic [31:0] win_start, pk_time, fl_time, fm_time, lm_time, ll_time, lh_time;
	logic [15:0] pk_val, fl_val, ll_val, lh_val;
	logic [2:0] seen;

	metrics_t pending_metrics[$];
	row_t directed[$];
	int errors = 0;
	bit long_hold = 0;

	function automatic logic [31:0] slope_of(longint va, longint vb, longint ta, longint tb,
			output bit ok);
		longint dt, q;
		dt = ta - tb;
		ok = (dt != 0);
		if (!ok)
			return '0;
		q = ((va - vb) * 65536) / dt;
		if (q > 64'sh7FFF_FFFF)
			q = 64'sh7FFF_FFFF;
		if (q < -64'sh8000_0000)
			q = -64'sh8000_0000;
		return q[31:0];
	endfunction

	function automatic logic [32:0] diff33(logic [31:0] a, logic [31:0] b);
		return {1'b0, a} - {1'b0, b};
	endfunction

	task automatic track_sample(sample_t s, output bit emits, output metrics_t r);
		bit ok;
		logic [31:0] q;
		if (s.ws) begin
			seen = '0;
			win_start = s.stamp;
			pk_time = s.stamp;
			pk_val = s.value;
		end
		if (s.value > thr_low) begin
			if (!seen[0]) begin
				fl_time = s.stamp;
				fl_val = s.value;
			end
			ll_time = s.stamp;
			ll_val = s.value;
			seen[0] = 1;
		end
		if (s.value > thr_mid) begin
			if (!seen[1])
				fm_time = s.stamp;
			lm_time = s.stamp;
			seen[1] = 1;
		end
		if (s.value > thr_high) begin
			lh_time = s.stamp;
			lh_val = s.value;
			seen[2] = 1;
		end
		if (s.pk) begin
			pk_time = s.stamp;
			pk_val = s.value;
		end
		emits = s.we;
		r = '{default: '0};
		r.ttp = diff33(pk_time, win_start);
		if (seen[0]) begin
			r.rise = diff33(pk_time, fl_time);
			r.mask[0] = 1;
			q = slope_of(longint'(pk_val), longint'(fl_val), longint'(pk_time),
				longint'(fl_time), ok);
			if (ok) begin
				r.rslope = q;
				r.mask[1] = 1;
			end
			r.decay = diff33(ll_time, pk_time);
			r.mask[2] = 1;
			if (seen[2]) begin
				q = slope_of(longint'(ll_val), longint'(lh_val), longint'(ll_time),
					longint'(lh_time), ok);
				if (ok) begin
					r.dslope = q;
					r.mask[3] = 1;
				end
			end
		end
		if (seen[1]) begin
			r.hmw = diff33(lm_time, fm_time);
			r.mask[4] = 1;
		end
		r.trans = s.stamp - win_start;
	endtask

	task automatic report(string field, logic [32:0] got, logic [32:0] want);
		$display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// send one request; prediction is taken at the accepting edge
	task automatic offer(sample_t s, bit typed, metrics_t want);
		bit emits;
		metrics_t r;
		@(negedge clk);
		sample_value = s.value;
		sample_time = s.stamp;
		window_start = s.ws;
		window_end = s.we;
		peak_marker = s.pk;
		in_valid = 1;
		do
			@(posedge clk);
		while (in_stall);
		track_sample(s, emits, r);
		if (emits)
			pending_metrics.push_back(typed ? want : r);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		in_valid = 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		case (idx)
			REG_LOW: thr_low = data;
			REG_MID: thr_mid = data;
			REG_HIGH: thr_high = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending_metrics.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_row(logic [15:0] v, logic [31:0] t, bit ws, bit we, bit pk);
		row_t r;
		r = '{default: '0};
		r.s = '{v, t, ws, we, pk};
		directed.push_back(r);
	endtask

	// random window: random values around one peak sample, with sender bursts and gaps
	int burst_left = 0;

	task automatic send(sample_t s);
		metrics_t none;
		none = '{default: '0};
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 8));
		end
		burst_left--;
		offer(s, 0, none);
	endtask

	task automatic random_window(inout int sent);
		int n, top;
		logic [15:0] peak_v;
		logic [31:0] t;
		sample_t s;
		n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		top = $urandom_range(0, n - 1);
		peak_v = 16'($urandom);
		t = $urandom;
		for (int i = 0; i < n; i++) begin
			s.value = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
				16'($urandom_range(0, peak_v));
			if (i == top)
				s.value = peak_v;
			s.stamp = t;
			s.ws = (i == 0);
			s.we = (i == n - 1);
			s.pk = (i == top) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
			case ($urandom_range(0, 3))
				0: t = t;
				1: t = t + 1;
				2: t = t + $urandom_range(2, 1000);
				default: t = t + $urandom_range(1, 20);
			endcase
			send(s);
			sent++;
		end
	endtask

	task automatic random_phase(int count);
		int sent;
		sample_t s;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				s.value = 16'($urandom);
				s.stamp = $urandom;
				s.ws = 1'($urandom_range(0, 1));
				s.we = 1'($urandom_range(0, 1));
				s.pk = 1'($urandom_range(0, 1));
				send(s);
				sent++;
			end else
				random_window(sent);
		end
		drain();
	endtask

	always @(posedge clk) begin
		metrics_t e;
		if (out_valid && !out_stall) begin
			if (pending_metrics.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				e = pending_metrics.pop_front();
				if (time_to_peak !== e.ttp) report("time_to_peak", time_to_peak, e.ttp);
				if (rise_time !== e.rise) report("rise_time", rise_time, e.rise);
				if (decay_time !== e.decay) report("decay_time", decay_time, e.decay);
				if (half_max_width !== e.hmw) report("half_max_width", half_max_width, e.hmw);
				if (transient_time !== e.trans)
					report("transient_time", 33'(transient_time), 33'(e.trans));
				if (rise_slope !== e.rslope)
					report("rise_slope", 33'(unsigned'(rise_slope)), 33'(e.rslope));
				if (decay_slope !== e.dslope)
					report("decay_slope", 33'(unsigned'(decay_slope)), 33'(e.dslope));
				if (valid_mask !== e.mask)
					report("valid_mask", 33'(valid_mask), 33'(e.mask));
			end
		end
	end

	// receiver: stretches of differing stall density, plus one long hold
	initial begin
		int stretch, pct;
		forever begin
			if (long_hold) begin
				long_hold = 0;
				@(negedge clk);
				out_stall = 1;
				repeat (400) @(negedge clk);
			end
			stretch = $urandom_range(20, 200);
			case ($urandom_range(0, 2))
				0: pct = 0;
				1: pct = 25;
				default: pct = 75;
			endcase
			repeat (stretch) begin
				@(negedge clk);
				out_stall = ($urandom_range(0, 99) < pct);
			end
		end
	end

	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		metrics_t m;
		thr_low = LOW_THR_RST;
		thr_mid = MID_THR_RST;
		thr_high = HIGH_THR_RST;
		win_start = '0; pk_time = '0; fl_time = '0; fm_time = '0; lm_time = '0;
		ll_time = '0; lh_time = '0; pk_val = '0; fl_val = '0; ll_val = '0; lh_val = '0;
		seen = '0;

		// all below threshold: nothing crossed
		add_row(16'd0, 32'd100, 1, 1, 0);
		directed[$].typed = 1;
		// full scale at the top timestamp: every crossing at one time, slopes void
		add_row(16'hFFFF, 32'hFFFF_FFFF, 1, 1, 1);
		m = '{default: '0};
		m.mask = 5'b10101;
		directed[$].typed = 1;
		directed[$].want = m;
		// ordinary pulse
		add_row(16'd0, 32'd1000, 1, 0, 0);
		add_row(16'd10000, 32'd1010, 0, 0, 0);
		add_row(16'd20000, 32'd1020, 0, 0, 0);
		add_row(16'hFFFF, 32'd1030, 0, 0, 1);
		add_row(16'd30000, 32'd1040, 0, 0, 0);
		add_row(16'd8000, 32'd1050, 0, 1, 0);
		// samples after window end keep accumulating
		add_row(16'd40000, 32'd1060, 0, 0, 0);
		add_row(16'd7000, 32'd1070, 0, 1, 0);
		// no peak marker, time wraps across the window
		add_row(16'd20000, 32'hFFFF_FFF0, 1, 0, 0);
		add_row(16'd40000, 32'd3, 0, 0, 0);
		add_row(16'd100, 32'd5, 0, 1, 0);
		// several peak markers, the last wins
		add_row(16'd30000, 32'd200, 1, 0, 1);
		add_row(16'd50000, 32'd210, 0, 0, 1);
		add_row(16'd45000, 32'd220, 0, 0, 1);
		add_row(16'd7000, 32'd230, 0, 1, 0);
		// positive slope saturation
		add_row(16'd6555, 32'd500, 1, 0, 0);
		add_row(16'hFFFF, 32'd501, 0, 1, 1);
		// negative slope saturation
		add_row(16'hFFFF, 32'd50, 1, 0, 0);
		add_row(16'd0, 32'd51, 0, 1, 1);
		// first sample of a window is also its end
		add_row(16'h7FFF, 32'h8000_0000, 1, 1, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (directed[i])
			offer(directed[i].s, directed[i].typed, directed[i].want);
		drain();

		cfg_write(REG_LOW, 16'd0);
		cfg_write(REG_MID, 16'd0);
		cfg_write(REG_HIGH, 16'd0);
		cfg_write(REG_SPARE, 16'hFFFF);
		long_hold = 1;
		random_phase(300);

		cfg_write(REG_LOW, 16'hFFFF);
		cfg_write(REG_MID, 16'hFFFF);
		cfg_write(REG_HIGH, 16'hFFFF);
		random_phase(250);

		cfg_write(REG_LOW, LOW_THR_RST);
		cfg_write(REG_MID, MID_THR_RST);
		cfg_write(REG_HIGH, HIGH_THR_RST);
		random_phase(400);

		repeat (3) begin
			cfg_write(REG_LOW, 16'($urandom_range(0, 20000)));
			cfg_write(REG_MID, 16'($urandom_range(10000, 40000)));
			cfg_write(REG_HIGH, 16'($urandom_range(20000, 65535)));
			random_phase(270);
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// File: sim.f
src/ptm_pkg.sv
src/ptm_div.sv
src/ptm_datapath.sv
src/ptm_ctrl.sv
src/pulse_transient_metrics.sv
tb/pulse_transient_metrics_test.sv
